>>> hdl/fibfd_pkg.sv
`default_nettype none
package fibfd_pkg;

  localparam int unsigned INDEX_BITS_DEFAULT = 63;
  localparam int unsigned MOD_W = 31;
  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TWICE,
    ST_DIFF,
    ST_MUL_EVEN,
    ST_MUL_AA,
    ST_MUL_BB,
    ST_ODD,
    ST_NEXT,
    ST_FINISH
  } state_t;

  typedef enum logic {
    OP_ADD,
    OP_SUB
  } op_t;

endpackage
`default_nettype wire

>>> hdl/fibonacci_fast_doubling_mod_unit.sv
// each index bit runs three bit-serial modular multiplies and four modular add/subtract steps
// all arithmetic runs on one shared add/subtract-and-reduce unit, one operation per cycle
// a new item is taken only in idle, after the last result is loaded; it is taken while a result waits
// reset (rst, synchronous, active high): idle, no result pending, modulus back to 1000000007
`default_nettype none
module fibonacci_fast_doubling_mod_unit #(
  parameter int unsigned INDEX_BITS = fibfd_pkg::INDEX_BITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fibfd_pkg::MOD_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [INDEX_BITS-1:0]       index,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [fibfd_pkg::MOD_W-1:0]      fib_n,
  output logic [fibfd_pkg::MOD_W-1:0]      fib_next
);
  import fibfd_pkg::*;

  localparam int unsigned LVL_W = $clog2(INDEX_BITS + 1);
  localparam int unsigned BIT_W = $clog2(MOD_W);

  state_t state, state_next;

  logic [MOD_W-1:0]      modulus;
  logic [MOD_W-1:0]      m_reg;
  logic [MOD_W-1:0]      m_eff;
  logic [INDEX_BITS-1:0] n_reg;
  logic [LVL_W-1:0]      level;
  logic [BIT_W-1:0]      mbit;
  logic [MOD_W-1:0]      fa;
  logic [MOD_W-1:0]      fb;
  logic [MOD_W-1:0]      tb;
  logic [MOD_W-1:0]      even;
  logic [MOD_W-1:0]      aa;
  logic [MOD_W-1:0]      acc;

  logic                  accept;
  logic                  load_out;
  logic                  mul_state;
  logic [MOD_W-1:0]      mul_x;
  logic [MOD_W-1:0]      mul_y;
  logic                  ybit;

  op_t                   op;
  logic [MOD_W:0]        p;
  logic [MOD_W:0]        q;
  logic [MOD_W+1:0]      sum;
  logic [MOD_W+1:0]      m1;
  logic [MOD_W+1:0]      m2;
  logic [MOD_W+1:0]      r;
  logic [MOD_W-1:0]      res;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign load_out  = !out_valid || !out_stall;
  assign m_eff     = (modulus == '0) ? MOD_W'(1) : modulus;
  assign mul_state = (state == ST_MUL_EVEN) || (state == ST_MUL_AA) || (state == ST_MUL_BB);

  // multiplier operand select
  always_comb begin
    mul_x = fb;
    mul_y = fb;
    case (state)
      ST_MUL_EVEN: begin
        mul_x = fa;
        mul_y = tb;
      end
      ST_MUL_AA: begin
        mul_x = fa;
        mul_y = fa;
      end
      default: begin
        mul_x = fb;
        mul_y = fb;
      end
    endcase
  end

  assign ybit = mul_y[mbit];

  // shared modular add / subtract unit
  always_comb begin
    op = OP_ADD;
    p  = {1'b0, fb};
    q  = {1'b0, fb};
    case (state)
      ST_DIFF: begin
        op = OP_SUB;
        p  = {1'b0, tb};
        q  = {1'b0, fa};
      end
      ST_MUL_EVEN, ST_MUL_AA, ST_MUL_BB: begin
        p = {acc, 1'b0};
        q = ybit ? {1'b0, mul_x} : '0;
      end
      ST_ODD: begin
        p = {1'b0, aa};
        q = {1'b0, acc};
      end
      ST_NEXT: begin
        p = {1'b0, even};
        q = {1'b0, tb};
      end
      default: begin
        p = {1'b0, fb};
        q = {1'b0, fb};
      end
    endcase
  end

  always_comb begin
    sum = {1'b0, p} + {1'b0, q};
    m1  = {2'b00, m_reg};
    m2  = {1'b0, m_reg, 1'b0};
    r   = sum;
    case (op)
      OP_SUB: begin
        if (p >= q) begin
          r = {1'b0, p} - {1'b0, q};
        end else begin
          r = {1'b0, p} + m1 - {1'b0, q};
        end
      end
      default: begin
        if (sum >= m2) begin
          r = sum - m2;
        end else if (sum >= m1) begin
          r = sum - m1;
        end else begin
          r = sum;
        end
      end
    endcase
    res = r[MOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_TWICE;
        end
      end
      ST_TWICE:    state_next = ST_DIFF;
      ST_DIFF:     state_next = ST_MUL_EVEN;
      ST_MUL_EVEN: begin
        if (mbit == '0) begin
          state_next = ST_MUL_AA;
        end
      end
      ST_MUL_AA: begin
        if (mbit == '0) begin
          state_next = ST_MUL_BB;
        end
      end
      ST_MUL_BB: begin
        if (mbit == '0) begin
          state_next = ST_ODD;
        end
      end
      ST_ODD:      state_next = ST_NEXT;
      ST_NEXT: begin
        state_next = (level == '0) ? ST_FINISH : ST_TWICE;
      end
      ST_FINISH: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      modulus <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          m_reg <= m_eff;
          n_reg <= index;
          level <= LVL_W'(INDEX_BITS - 1);
          fa    <= '0;
          fb    <= (m_eff == MOD_W'(1)) ? '0 : MOD_W'(1);
        end
      end
      ST_TWICE: begin
        tb <= res;
      end
      ST_DIFF: begin
        tb   <= res;
        acc  <= '0;
        mbit <= BIT_W'(MOD_W - 1);
      end
      ST_MUL_EVEN, ST_MUL_AA, ST_MUL_BB: begin
        if (mbit == '0) begin
          acc  <= (state == ST_MUL_BB) ? res : '0;
          mbit <= BIT_W'(MOD_W - 1);
          if (state == ST_MUL_EVEN) begin
            even <= res;
          end
          if (state == ST_MUL_AA) begin
            aa <= res;
          end
        end else begin
          acc  <= res;
          mbit <= mbit - 1'b1;
        end
      end
      ST_ODD: begin
        tb <= res;
      end
      ST_NEXT: begin
        if (n_reg[INDEX_BITS-1]) begin
          fa <= tb;
          fb <= res;
        end else begin
          fa <= even;
          fb <= tb;
        end
        n_reg <= n_reg << 1;
        level <= level - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && load_out) begin
      fib_n    <= fa;
      fib_next <= fb;
    end
  end

  a_fa_reduced: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (fa < m_reg))
    else $error("fa not reduced");

  a_fb_reduced: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (fb < m_reg))
    else $error("fb not reduced");

  a_acc_reduced: assert property (@(posedge clk) disable iff (rst)
    mul_state |-> (acc < m_reg))
    else $error("multiply accumulator not reduced");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && load_out) |=> (out_valid && state == ST_IDLE))
    else $error("result not loaded on finish");

endmodule
`default_nettype wire
